@@ rtl/lfsr_filter_stream_cipher_macros.svh @@
// assertion macros shared by the cipher rtl
// used by lfsc_seq and the top level; needs nothing else
`ifndef LFSR_FILTER_STREAM_CIPHER_MACROS_SVH
`define LFSR_FILTER_STREAM_CIPHER_MACROS_SVH

// clocked assertion, off while reset is held
`define LFSC_ASSERT_CLK(clk, rst_n, label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same, on the usual clock and reset names
`define LFSC_ASSERT(label, prop, msg) \
    `LFSC_ASSERT_CLK(i_clk, i_rst_n, label, prop, msg)

`endif

@@ rtl/lfsc_pkg.sv @@
// types, constants and the filter function of the lfsr stream cipher
// no dependencies; imported by every module of the block
`default_nettype none

package lfsc_pkg;

    localparam int STATE_W    = 48;
    localparam int WORD_W     = 32;
    localparam int KEY_W      = 48;
    localparam int SEED_KEY_W = 16;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int INIT_STEPS = 32;
    localparam int MIX_STEPS  = 16;
    localparam int CNT_W      = 5;

    localparam logic [15:0]        F4A_WORD = 16'h2C79;
    localparam logic [15:0]        F4B_WORD = 16'h6671;
    localparam logic [31:0]        F5_WORD  = 32'h7907287B;
    localparam logic [STATE_W-1:0] TAP_MASK = 48'hC400_0001_9917;

    localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
    localparam logic [OP_W-1:0] OP_CRYPT = 2'd1;
    localparam logic [OP_W-1:0] OP_BIT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TAG_UID    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECRET_KEY = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_MIX,
        S_CRYPT,
        S_BIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic inject;
        logic inj_bit;
    } t_lfsr_ctl;

    // nonlinear output of the register as it stands before a shift
    function automatic logic lfsc_filter(input logic [STATE_W-1:0] s);
        logic [3:0] ia;
        logic [3:0] ib;
        logic [4:0] i5;
        ia = {s[8], s[4], s[2], s[1]};
        ib = {s[32], s[22], s[16], s[10]};
        i5 = {s[32], s[16], s[8], F4B_WORD[ib], F4A_WORD[ia]};
        return F5_WORD[i5];
    endfunction

endpackage

`default_nettype wire

@@ rtl/lfsc_lfsr.sv @@
// 48-bit shift register with tap feedback, nonlinear filter and bit 0 injection
// depends on lfsc_pkg
`default_nettype none

module lfsc_lfsr (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire lfsc_pkg::t_lfsr_ctl     i_ctl,
    input  wire logic [lfsc_pkg::STATE_W-1:0] i_seed,
    output logic                         o_ks
);
    import lfsc_pkg::*;

    logic [STATE_W-1:0] r_state;
    logic [STATE_W-1:0] n_state;
    logic               fb;

    assign o_ks = lfsc_filter(r_state);
    assign fb   = ^(r_state & TAP_MASK);

    always_comb begin
        n_state = r_state;
        if (i_ctl.load) begin
            n_state = i_seed;
        end else if (i_ctl.step) begin
            n_state = {fb, r_state[STATE_W-1:1]};
            // injection lands after the shift
            if (i_ctl.inject) begin
                n_state[0] = r_state[1] ^ i_ctl.inj_bit ^ o_ks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lfsc_seq.sv @@
// sequencer: operation fsm, step counter, nonce/key and data bit-serial shifters
// depends on lfsc_pkg and the assertion macro header
`default_nettype none
`include "lfsr_filter_stream_cipher_macros.svh"

module lfsc_seq (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire logic [lfsc_pkg::OP_W-1:0]       i_operation,
    input  wire logic [lfsc_pkg::WORD_W-1:0]     i_nonce,
    input  wire logic [lfsc_pkg::WORD_W-1:0]     i_data_word,
    input  wire logic [lfsc_pkg::WORD_W-1:0]     i_key_hi,
    input  wire logic                            i_ks,
    input  wire logic                            i_out_free,
    output logic                                 o_idle,
    output lfsc_pkg::t_lfsr_ctl                  o_ctl,
    output logic                                 o_res_load,
    output logic [lfsc_pkg::WORD_W-1:0]          o_res
);
    import lfsc_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    n_cnt;
    logic [WORD_W-1:0]   r_nonce;
    logic [WORD_W-1:0]   n_nonce;
    logic [WORD_W-1:0]   r_key;
    logic [WORD_W-1:0]   n_key;
    logic [WORD_W-1:0]   r_acc;
    logic [WORD_W-1:0]   n_acc;
    logic                accept;
    logic                last_init;
    logic                last_mix;
    logic                last_word;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign last_init = (r_cnt == CNT_W'(INIT_STEPS - 1));
    assign last_mix  = (r_cnt == CNT_W'(MIX_STEPS - 1));
    assign last_word = (r_cnt == CNT_W'(WORD_W - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_operation)
                        OP_INIT:  n_state = S_INIT;
                        OP_CRYPT: n_state = S_CRYPT;
                        OP_BIT:   n_state = S_BIT;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_INIT:  if (last_init) n_state = S_MIX;
            S_MIX:   if (last_mix) n_state = S_DONE;
            S_CRYPT: if (last_word) n_state = S_DONE;
            S_BIT:   n_state = S_DONE;
            S_DONE:  if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_idle         = (r_state == S_IDLE);
        o_ctl.load     = accept && (i_operation == OP_INIT);
        o_ctl.step     = 1'b0;
        o_ctl.inject   = 1'b0;
        o_ctl.inj_bit  = r_nonce[0] ^ r_key[0];
        o_res_load     = 1'b0;
        case (r_state)
            S_INIT: begin
                o_ctl.step   = 1'b1;
                o_ctl.inject = 1'b1;
            end
            S_MIX, S_CRYPT, S_BIT: o_ctl.step = 1'b1;
            S_DONE: o_res_load = i_out_free;
            default: ;
        endcase
    end

    assign o_res = r_acc;

    // counter and bit-serial shifters
    always_comb begin
        n_cnt   = r_cnt;
        n_nonce = r_nonce;
        n_key   = r_key;
        n_acc   = r_acc;
        if (accept) begin
            n_cnt   = '0;
            n_nonce = i_nonce;
            n_key   = i_key_hi;
            n_acc   = (i_operation == OP_CRYPT) ? i_data_word : '0;
        end else begin
            case (r_state)
                S_INIT: begin
                    n_cnt   = last_init ? '0 : r_cnt + 1'b1;
                    n_nonce = {1'b0, r_nonce[WORD_W-1:1]};
                    n_key   = {1'b0, r_key[WORD_W-1:1]};
                end
                S_MIX: n_cnt = r_cnt + 1'b1;
                S_CRYPT: begin
                    // lsb leaves, xored with the keystream bit, and rotates back in at the top
                    n_cnt = r_cnt + 1'b1;
                    n_acc = {r_acc[0] ^ i_ks, r_acc[WORD_W-1:1]};
                end
                S_BIT: n_acc = {{(WORD_W-1){1'b0}}, i_ks};
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nonce <= n_nonce;
        r_key   <= n_key;
        r_acc   <= n_acc;
    end

    `LFSC_ASSERT(a_load_not_step, !(o_ctl.load && o_ctl.step), "seed load during a step")
    `LFSC_ASSERT(a_init_to_mix, (r_state == S_INIT) && last_init |=> (r_state == S_MIX),
        "init phase did not end after its injections")
    `LFSC_ASSERT(a_done_to_idle, o_res_load |=> (r_state == S_IDLE),
        "sequencer stayed busy after handing off a result")

endmodule

`default_nettype wire

@@ rtl/lfsr_filter_stream_cipher.sv @@
// init loads the seed, steps the lfsr with nonce/key bit injection, then steps it to mix;
// crypt and bit step it once per result bit, one step per cycle; items are taken one at a time
// an output register holds a finished item while the next one is taken in
// reset (synchronous, active low) clears the lfsr, both key registers and the handshakes
// top level: configuration registers, output register, sequencer and lfsr
// depends on lfsc_pkg, lfsc_lfsr, lfsc_seq and the assertion macro header
`default_nettype none
`include "lfsr_filter_stream_cipher_macros.svh"

module lfsr_filter_stream_cipher (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [lfsc_pkg::OP_W-1:0]          i_operation,
    input  wire logic [lfsc_pkg::WORD_W-1:0]        i_nonce,
    input  wire logic [lfsc_pkg::WORD_W-1:0]        i_data_word,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [lfsc_pkg::WORD_W-1:0]             o_result_word,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [lfsc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [lfsc_pkg::KEY_W-1:0]         i_cfg_data
);
    import lfsc_pkg::*;

    logic [WORD_W-1:0]  r_tag_uid;
    logic [KEY_W-1:0]   r_secret_key;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_result;
    logic               idle;
    logic               out_free;
    logic               res_load;
    logic [WORD_W-1:0]  res;
    logic               ks;
    t_lfsr_ctl          ctl;
    logic [STATE_W-1:0] seed;

    assign o_cfg_ready   = 1'b1;
    assign o_in_stall    = !idle;
    assign o_out_valid   = r_out_valid;
    assign o_result_word = r_result;
    assign out_free      = !r_out_valid || !i_out_stall;
    assign seed          = {r_tag_uid, r_secret_key[SEED_KEY_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_uid    <= '0;
            r_secret_key <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_TAG_UID:    r_tag_uid    <= i_cfg_data[WORD_W-1:0];
                REG_SECRET_KEY: r_secret_key <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_result <= res;
        end
    end

    lfsc_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_nonce     (i_nonce),
        .i_data_word (i_data_word),
        .i_key_hi    (r_secret_key[KEY_W-1:SEED_KEY_W]),
        .i_ks        (ks),
        .i_out_free  (out_free),
        .o_idle      (idle),
        .o_ctl       (ctl),
        .o_res_load  (res_load),
        .o_res       (res)
    );

    lfsc_lfsr u_lfsr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_seed  (seed),
        .o_ks    (ks)
    );

    `LFSC_ASSERT(a_no_overwrite, res_load |-> out_free,
        "result register overwritten while its item is still pending")

endmodule

`default_nettype wire

@@ dv/lfsr_filter_stream_cipher_tb.sv @@
// self-checking testbench for the lfsr filter stream cipher: directed and random items,
// key register changes and random back-pressure, each result checked against a local predictor
// depends on lfsc_pkg and the lfsr_filter_stream_cipher rtl
`timescale 1ns / 100ps

module lfsr_filter_stream_cipher_tb;
    import lfsc_pkg::*;

    localparam logic [OP_W-1:0]    OP_UNUSED   = 2'd3;
    localparam logic [15:0]        LUT_A       = 16'h2C79;
    localparam logic [15:0]        LUT_B       = 16'h6671;
    localparam logic [31:0]        LUT_C       = 32'h7907287B;
    localparam logic [STATE_W-1:0] FB_TAPS     = 48'hC400_0001_9917;
    localparam int                 QUIET_LIMIT = 3000;
    localparam int                 LONG_HOLD   = 250;
    localparam int                 END_WAIT    = 60;
    localparam int                 MAX_REPORTS = 10;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] word;
    } t_cipher_out;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [OP_W-1:0]      i_operation = '0;
    logic [WORD_W-1:0]    i_nonce     = '0;
    logic [WORD_W-1:0]    i_data_word = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [KEY_W-1:0]     i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [WORD_W-1:0]    o_result_word;
    logic                 o_cfg_ready;

    // predictor copy of the cipher register and the key registers
    logic [STATE_W-1:0] lfsr_q = '0;
    logic [WORD_W-1:0]  uid_q  = '0;
    logic [KEY_W-1:0]   key_q  = '0;

    t_cipher_out expected_words[$];
    t_cipher_out head_word;
    int          op_count [0:3];
    int          results_seen  = 0;
    int          fail_count    = 0;
    int          cfg_writes    = 0;
    int          rx_hold_req   = 0;
    int          rx_stall_left = 0;
    bit          idle_on       = 1'b1;

    lfsr_filter_stream_cipher uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_nonce       (i_nonce),
        .i_data_word   (i_data_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_word (o_result_word),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic filter_bit(input logic [STATE_W-1:0] s);
        logic [4:0] sel;
        sel[0]   = LUT_A[{s[8], s[4], s[2], s[1]}];
        sel[1]   = LUT_B[{s[32], s[22], s[16], s[10]}];
        sel[4:2] = {s[32], s[16], s[8]};
        return LUT_C[sel];
    endfunction

    // one register clock, keystream bit taken before the shift
    function automatic logic lfsr_tick();
        logic ks;
        ks = filter_bit(lfsr_q);
        lfsr_q = {^(lfsr_q & FB_TAPS), lfsr_q[STATE_W-1:1]};
        return ks;
    endfunction

    function automatic logic [WORD_W-1:0] cipher_result(input logic [OP_W-1:0] op,
                                                       input logic [WORD_W-1:0] nonce,
                                                       input logic [WORD_W-1:0] data);
        logic [WORD_W-1:0] res;
        logic              f;
        res = '0;
        case (op)
            OP_INIT: begin
                lfsr_q = {uid_q, key_q[SEED_KEY_W-1:0]};
                for (int i = 0; i < INIT_STEPS; i++) begin
                    f = lfsr_tick();
                    lfsr_q[0] = lfsr_q[0] ^ nonce[i] ^ key_q[i + SEED_KEY_W] ^ f;
                end
                for (int i = 0; i < MIX_STEPS; i++) f = lfsr_tick();
            end
            OP_CRYPT: begin
                for (int i = 0; i < WORD_W; i++) res[i] = lfsr_tick();
                res = res ^ data;
            end
            OP_BIT: res[0] = lfsr_tick();
            default: ; // unused code leaves the register alone
        endcase
        return res;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] nonce,
                             input logic [WORD_W-1:0] data);
        int          gap;
        t_cipher_out exp_word;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_nonce     <= nonce;
        i_data_word <= data;
        do @(posedge i_clk); while (o_in_stall);
        exp_word.op   = op;
        exp_word.word = cipher_result(op, nonce, data);
        expected_words.push_back(exp_word);
        op_count[op]++;
    endtask

    // valid stays high after an item, so lower it before waiting
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_words.size() != 0);
    endtask

    task automatic set_regs(input logic [WORD_W-1:0] uid, input logic [KEY_W-1:0] key);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_TAG_UID;
        i_cfg_data  <= {16'($urandom()), uid};
        do @(posedge i_clk); while (!o_cfg_ready);
        uid_q = uid;
        i_cfg_index <= REG_SECRET_KEY;
        i_cfg_data  <= key;
        do @(posedge i_clk); while (!o_cfg_ready);
        key_q = key;
        i_cfg_valid <= 1'b0;
        cfg_writes += 2;
    endtask

    // output side: check each result, then draw the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_words.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected result %h", $realtime, o_result_word);
            end else begin
                head_word = expected_words.pop_front();
                if (o_result_word !== head_word.word) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: op %0d result_word expected %h actual %h",
                                 $realtime, head_word.op, head_word.word, o_result_word);
                end
            end
            rx_stall_left = idle_on ? $urandom_range(0, 7) : 0;
        end
        if (rx_hold_req > 0) begin
            rx_stall_left = rx_hold_req;
            rx_hold_req   = 0;
        end
        if (rx_stall_left > 0) begin
            i_out_stall <= 1'b1;
            rx_stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("lfsr_filter_stream_cipher_tb failed");
        $finish;
    end

    // register and keys are zero straight out of reset
    task automatic test_zero_register();
        send_item(OP_BIT, '0, '0);
        send_item(OP_CRYPT, '0, '0);
        send_item(OP_UNUSED, '1, '1);
        send_item(OP_BIT, $urandom(), $urandom());
        send_item(OP_CRYPT, '1, '1);
    endtask

    task automatic test_directed_ops();
        set_regs('1, '1);
        send_item(OP_INIT, '0, '1);
        send_item(OP_CRYPT, '1, '0);
        send_item(OP_CRYPT, '0, '1);
        send_item(OP_BIT, '1, '1);
        send_item(OP_UNUSED, '0, '0);
        send_item(OP_BIT, '0, '0);
        send_item(OP_INIT, '1, '0);
        send_item(OP_CRYPT, $urandom(), 32'hA5A5_5A5A);
        set_regs(32'h8000_0001, 48'h8000_0000_0001);
        send_item(OP_INIT, 32'h8000_0001, '0);
        send_item(OP_CRYPT, '0, 32'h0000_0001);
        send_item(OP_BIT, '0, '0);
        set_regs('0, '0);
        send_item(OP_INIT, '0, '0);
        send_item(OP_CRYPT, '0, '0);
        send_item(OP_UNUSED, '1, '1);
        send_item(OP_BIT, '0, '0);
    endtask

    // mostly an init followed by a run of crypt and bit items, some stray items between
    task automatic test_random_traffic();
        int              sent;
        int              run_len;
        logic [OP_W-1:0] op;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_regs('1, '0);
                1: set_regs('0, '1);
                default: set_regs($urandom(), KEY_W'({$urandom(), $urandom()}));
            endcase
            idle_on = (phase % 3 != 2);
            sent = 0;
            while (sent < 130) begin
                if ($urandom_range(0, 9) < 8) begin
                    send_item(OP_INIT, $urandom(), $urandom());
                    sent++;
                    run_len = $urandom_range(2, 16);
                    repeat (run_len) begin
                        op = ($urandom_range(0, 9) < 7) ? OP_CRYPT : OP_BIT;
                        send_item(op, $urandom(), $urandom());
                        sent++;
                    end
                end else begin
                    op = OP_W'($urandom_range(0, 3));
                    send_item(op, $urandom(), $urandom());
                    sent++;
                end
            end
        end
        idle_on = 1'b1;
    endtask

    // receiver holds off while items keep coming, so the input side backs up
    task automatic test_output_backpressure();
        idle_on     = 1'b0;
        rx_hold_req = LONG_HOLD;
        send_item(OP_INIT, $urandom(), $urandom());
        repeat (11) send_item($urandom_range(0, 1) ? OP_CRYPT : OP_BIT, $urandom(), $urandom());
        idle_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        repeat (6) send_item($urandom_range(0, 1) ? OP_CRYPT : OP_BIT, $urandom(), $urandom());
        drain_results();
        send_item(OP_INIT, $urandom(), $urandom());
        repeat (5) send_item($urandom_range(0, 1) ? OP_CRYPT : OP_BIT, $urandom(), $urandom());
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_zero_register();
        test_directed_ops();
        test_random_traffic();
        test_output_backpressure();
        test_sender_pause();
        drain_results();
        repeat (END_WAIT) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            $display("%0d results never arrived", expected_words.size());
            fail_count += expected_words.size();
        end
        $display("covered %0d init, %0d crypt, %0d bit, %0d unused-code items; %0d results",
                 op_count[0], op_count[1], op_count[2], op_count[3], results_seen);
        $display("%0d key register writes, long output hold and full sender pause included",
                 cfg_writes);
        if (fail_count == 0)
            $display("lfsr_filter_stream_cipher_tb passed");
        else
            $display("lfsr_filter_stream_cipher_tb failed");
        $finish;
    end

endmodule
